[design/assert_macros.svh]
// Assertion macros used by the checker file of the tone queue sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TQS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tone queue sequencer check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TQS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tone queue sequencer check failed");

`endif

[design/tqs_pkg.sv]
// Types, constants and field layout of the tone queue sequencer.
`default_nettype none
package tqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 6;

	localparam int FREQ_W  = 16;
	localparam int DUR_W   = 8;
	localparam int TICK_W  = 32;
	localparam int CLK_W   = 26;
	localparam int TPU_W   = 8;
	localparam int CMP_W   = 16;
	localparam int QC_W    = 3;
	localparam int KIND_W  = 2;
	localparam int PROD_W  = TPU_W + DUR_W;

	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = KIND_W;
	localparam int M_TDATA_W = 24;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = CLK_W;

	// input tdata layout
	localparam int IN_FREQ_LSB = 0;
	localparam int IN_DUR_LSB  = IN_FREQ_LSB + FREQ_W;
	localparam int IN_QUIET_BIT = IN_DUR_LSB + DUR_W;
	localparam int IN_NOW_LSB  = IN_QUIET_BIT + 1;
	localparam int IN_EN_BIT   = IN_NOW_LSB + TICK_W;

	// output tdata layout
	localparam int OUT_CMP_LSB  = 0;
	localparam int OUT_TOG_BIT  = OUT_CMP_LSB + CMP_W;
	localparam int OUT_RST_BIT  = OUT_TOG_BIT + 1;
	localparam int OUT_ACC_BIT  = OUT_RST_BIT + 1;
	localparam int OUT_PLAY_BIT = OUT_ACC_BIT + 1;
	localparam int OUT_QC_LSB   = OUT_PLAY_BIT + 1;
	localparam int OUT_QC_MSB   = OUT_QC_LSB + QC_W - 1;

	localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TPU      = 4'd3;

	localparam logic [FREQ_W-1:0] RST_FREQ_MIN = 16'd150;
	localparam logic [FREQ_W-1:0] RST_FREQ_MAX = 16'd1000;
	localparam logic [CLK_W-1:0]  RST_CLOCK_HZ = 26'd8000000;
	localparam logic [TPU_W-1:0]  RST_TPU      = 8'd10;
	localparam logic [CMP_W-1:0]  RST_COMPARE  = 16'd9090;

	// restoring divider: one quotient bit per step over the clock rate
	localparam int DIV_STEPS = CLK_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int DVS_W     = FREQ_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} q_cmd_t;

endpackage
`default_nettype wire

[design/tone_queue_sequencer_top.sv]
// Top level of the tone queue sequencer: sequencer, state, config and stream ports.
//
//  channel  direction  handshake             payload
//  s_*      in         s_tvalid / s_tready   s_tuser kind, s_tdata tone and event fields
//  m_*      out        m_tvalid / m_tready   m_tdata compare value and status
//  cfg_*    in         cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// Enqueue, clear and compare events that start no tone: ST_EXEC, then ST_RESP, where the result loads.
// A compare event that starts a tone: ST_EXEC, then ST_DIV until the 26-step divider is done, then ST_RESP.
// s_tready is high only while no item is at work, from the cycle after the result loads;
// one finished result may wait on m_tready and holds off the next result load.
// Reset clears the fill count and timing state; no clearing pass. cfg_ready is always high.
`default_nettype none
module tone_queue_sequencer_top #(
	parameter int QUEUE_DEPTH = tqs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [15:0] tone_frequency, [23:16] tone_duration, [24] quiet, [56:25] now_ticks,
	// [57] sound_enable, [63:58] zero
	input  wire logic [tqs_pkg::S_TDATA_W-1:0]     s_tdata,
	// [1:0] kind
	input  wire logic [tqs_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [15:0] compare_value, [16] toggle_on, [17] restart_timer, [18] accepted,
	// [19] playing, [22:20] queue_count, [23] zero
	output logic [tqs_pkg::M_TDATA_W-1:0]          m_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tqs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tqs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QC_W  = tqs_pkg::QC_W;

	tqs_pkg::state_t state_q, state_nxt;

	logic [tqs_pkg::FREQ_W-1:0] freq_min_q;
	logic [tqs_pkg::FREQ_W-1:0] freq_max_q;
	logic [tqs_pkg::CLK_W-1:0]  clock_hz_q;
	logic [tqs_pkg::TPU_W-1:0]  tpu_q;

	logic [tqs_pkg::KIND_W-1:0] kind_q;
	logic [tqs_pkg::FREQ_W-1:0] freq_q;
	logic [tqs_pkg::DUR_W-1:0]  dur_q;
	logic                       quiet_q;
	logic [tqs_pkg::TICK_W-1:0] now_q;
	logic                       en_q;

	logic [tqs_pkg::TICK_W-1:0] stop_q;
	logic [tqs_pkg::CMP_W-1:0]  cmp_q;
	logic                       tog_q;
	logic                       restart_q;
	logic                       accepted_q;
	logic                       m_tvalid_q;
	logic [tqs_pkg::M_TDATA_W-1:0] m_tdata_q;

	tqs_pkg::q_cmd_t            q_cmd;
	logic [tqs_pkg::FREQ_W-1:0] head_freq;
	logic [tqs_pkg::DUR_W-1:0]  head_dur;
	logic [CNT_W-1:0]           count;
	logic [CNT_W+QC_W-1:0]      count_ext;

	logic                       div_start;
	logic                       div_done;
	logic [tqs_pkg::CMP_W-1:0]  div_result;

	logic                       in_acc;
	logic                       out_load;
	logic                       is_enq;
	logic                       is_clr;
	logic                       is_cmp;
	logic                       freq_ok;
	logic                       push_ok;
	logic                       time_up;
	logic                       q_nonempty;
	logic                       do_pop;
	logic [tqs_pkg::PROD_W-1:0] span;
	logic [tqs_pkg::TICK_W-1:0] stop_nxt;

	tqs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.push_freq (freq_q),
		.push_dur  (dur_q),
		.head_freq (head_freq),
		.head_dur  (head_dur),
		.count     (count)
	);

	tqs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clock_hz_q),
		.freq     (head_freq),
		.done     (div_done),
		.result   (div_result)
	);

	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;

	always_comb begin
		is_enq     = kind_q == tqs_pkg::KIND_ENQUEUE;
		is_clr     = kind_q == tqs_pkg::KIND_CLEAR;
		is_cmp     = kind_q == tqs_pkg::KIND_COMPARE;
		q_nonempty = count != '0;
		freq_ok    = (freq_q != '0) && (freq_q >= freq_min_q) && (freq_q <= freq_max_q);
		push_ok    = is_enq && freq_ok && !(quiet_q && q_nonempty)
			&& (count < CNT_W'(QUEUE_DEPTH));
		time_up    = now_q > stop_q;
		do_pop     = is_cmp && en_q && time_up && q_nonempty;
		span       = {{tqs_pkg::DUR_W{1'b0}}, tpu_q} * {{tqs_pkg::TPU_W{1'b0}}, head_dur};
		stop_nxt   = now_q + tqs_pkg::TICK_W'(span);
		count_ext  = (CNT_W + QC_W)'(count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		s_tready   = 1'b0;
		q_cmd      = '0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			tqs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = tqs_pkg::ST_EXEC;
				end
			end
			tqs_pkg::ST_EXEC: begin
				q_cmd.push  = push_ok;
				q_cmd.pop   = do_pop;
				q_cmd.clear = is_clr || (is_cmp && !en_q);
				div_start   = do_pop;
				state_nxt   = do_pop ? tqs_pkg::ST_DIV : tqs_pkg::ST_RESP;
			end
			tqs_pkg::ST_DIV: begin
				if (div_done) begin
					state_nxt = tqs_pkg::ST_RESP;
				end
			end
			tqs_pkg::ST_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					out_load  = 1'b1;
					state_nxt = tqs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = tqs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_min_q <= tqs_pkg::RST_FREQ_MIN;
			freq_max_q <= tqs_pkg::RST_FREQ_MAX;
			clock_hz_q <= tqs_pkg::RST_CLOCK_HZ;
			tpu_q      <= tqs_pkg::RST_TPU;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tqs_pkg::CFG_FREQ_MIN: freq_min_q <= cfg_data[tqs_pkg::FREQ_W-1:0];
				tqs_pkg::CFG_FREQ_MAX: freq_max_q <= cfg_data[tqs_pkg::FREQ_W-1:0];
				tqs_pkg::CFG_CLOCK_HZ: clock_hz_q <= cfg_data[tqs_pkg::CLK_W-1:0];
				tqs_pkg::CFG_TPU:      tpu_q      <= cfg_data[tqs_pkg::TPU_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q  <= s_tuser;
			freq_q  <= s_tdata[tqs_pkg::IN_DUR_LSB-1:tqs_pkg::IN_FREQ_LSB];
			dur_q   <= s_tdata[tqs_pkg::IN_QUIET_BIT-1:tqs_pkg::IN_DUR_LSB];
			quiet_q <= s_tdata[tqs_pkg::IN_QUIET_BIT];
			now_q   <= s_tdata[tqs_pkg::IN_EN_BIT-1:tqs_pkg::IN_NOW_LSB];
			en_q    <= s_tdata[tqs_pkg::IN_EN_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q     <= '0;
			cmp_q      <= tqs_pkg::RST_COMPARE;
			tog_q      <= 1'b0;
			restart_q  <= 1'b0;
			accepted_q <= 1'b0;
		end else begin
			if (state_q == tqs_pkg::ST_EXEC) begin
				accepted_q <= push_ok;
				restart_q  <= do_pop;
				if (is_cmp) begin
					if (!en_q) begin
						tog_q <= 1'b0;
					end else if (time_up) begin
						tog_q <= q_nonempty;
						if (q_nonempty) begin
							stop_q <= stop_nxt;
						end
					end
				end
			end
			if (state_q == tqs_pkg::ST_DIV && div_done) begin
				cmp_q <= div_result;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, count_ext[QC_W-1:0], q_nonempty, accepted_q, restart_q,
				tog_q, cmp_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

[design/tqs_div.sv]
// Restoring divider: clock rate over twice the tone frequency, less one, saturated.
`default_nettype none
module tqs_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [tqs_pkg::CLK_W-1:0]    dividend,
	input  wire logic [tqs_pkg::FREQ_W-1:0]   freq,
	output logic                              done,
	output logic [tqs_pkg::CMP_W-1:0]         result
);

	localparam int QUO_W = tqs_pkg::CLK_W;
	localparam int REM_W = tqs_pkg::DVS_W;
	localparam int CNT_W = tqs_pkg::DIV_CNT_W;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(tqs_pkg::DIV_STEPS - 1);
	localparam logic [QUO_W-1:0] SAT_LIMIT = QUO_W'(2 ** tqs_pkg::CMP_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [REM_W-1:0] dvs_q;

	logic [REM_W:0]   rem_sh;
	logic [REM_W:0]   diff;
	logic             ge;
	logic [REM_W-1:0] rem_nxt;
	logic [QUO_W-1:0] quo_nxt;
	logic [QUO_W-1:0] quo_m1;

	always_comb begin
		rem_sh  = {rem_q, quo_q[QUO_W-1]};
		diff    = rem_sh - {1'b0, dvs_q};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_nxt = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
		quo_nxt = {quo_q[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= {freq, 1'b0};
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	always_comb begin
		quo_m1 = quo_q - QUO_W'(1);
		priority if (quo_q == '0) begin
			result = '0;
		end else if (quo_q > SAT_LIMIT) begin
			result = '1;
		end else begin
			result = quo_m1[tqs_pkg::CMP_W-1:0];
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

[design/tqs_queue.sv]
// Shift-down tone queue: push at the fill count, pop from entry zero.
`default_nettype none
module tqs_queue #(
	parameter int DEPTH = tqs_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tqs_pkg::q_cmd_t                cmd,
	input  wire logic [tqs_pkg::FREQ_W-1:0]     push_freq,
	input  wire logic [tqs_pkg::DUR_W-1:0]      push_dur,
	output logic [tqs_pkg::FREQ_W-1:0]          head_freq,
	output logic [tqs_pkg::DUR_W-1:0]           head_dur,
	output logic [$clog2(DEPTH+1)-1:0]          count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [tqs_pkg::FREQ_W-1:0] freq_q [DEPTH];
	logic [tqs_pkg::DUR_W-1:0]  dur_q  [DEPTH];
	logic [CNT_W-1:0]           count_q;
	logic [IDX_W-1:0]           wr_idx;

	assign wr_idx = count_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.pop) begin
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				freq_q[i] <= freq_q[i+1];
				dur_q[i]  <= dur_q[i+1];
			end
		end else if (cmd.push) begin
			freq_q[wr_idx] <= push_freq;
			dur_q[wr_idx]  <= push_dur;
		end
	end

	assign head_freq = freq_q[0];
	assign head_dur  = dur_q[0];
	assign count     = count_q;

endmodule
`default_nettype wire

[design/tqs_checker.sv]
// Port-level checks of the tone queue sequencer and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module tqs_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	input  wire logic                              s_tready,
	input  wire logic [tqs_pkg::S_TDATA_W-1:0]     s_tdata,
	input  wire logic [tqs_pkg::S_TUSER_W-1:0]     s_tuser,
	input  wire logic                              m_tvalid,
	input  wire logic                              m_tready,
	input  wire logic [tqs_pkg::M_TDATA_W-1:0]     m_tdata,
	input  wire logic                              cfg_valid,
	input  wire logic                              cfg_ready,
	input  wire logic [tqs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tqs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic out_restart;
	logic out_toggle;
	logic out_accepted;
	logic out_playing;
	logic cfg_seen;
	logic in_seen;

	assign out_restart  = m_tdata[tqs_pkg::OUT_RST_BIT];
	assign out_toggle   = m_tdata[tqs_pkg::OUT_TOG_BIT];
	assign out_accepted = m_tdata[tqs_pkg::OUT_ACC_BIT];
	assign out_playing  = m_tdata[tqs_pkg::OUT_PLAY_BIT];
	assign cfg_seen     = cfg_valid && (cfg_index != '0 || cfg_data != '0);
	assign in_seen      = s_tvalid && (s_tuser != '0 || s_tdata != '0);

	`TQS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`TQS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`TQS_ASSERT_IMPL(a_restart_toggles, m_tvalid && out_restart, out_toggle)
	`TQS_ASSERT_IMPL(a_stored_plays, m_tvalid && out_accepted, out_playing)

	// cfg_ready is tied high; a write is never held off
	`TQS_ASSERT_IMPL(a_cfg_ready, cfg_seen || in_seen || cfg_valid, cfg_ready)

endmodule

bind tone_queue_sequencer_top tqs_checker u_tqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);
`default_nettype wire
